>>> rtl/hbep_pkg.sv
// Shared types and constants for the H-bridge effort to PWM converter.
`default_nettype none
package hbep_pkg;

  localparam int DUTY_BITS = 10;
  localparam int EFFORT_W  = 16;
  localparam int PCT_W     = 7;
  localparam int MAG_N_W   = EFFORT_W + PCT_W;
  localparam int FRAC_W    = EFFORT_W - 1;
  localparam int SCALED_W  = PCT_W + DUTY_BITS;
  // x / 100 as (x * RECIP_MUL) >> RECIP_SHIFT, exact for x up to 100 * (2^16 - 1)
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam int RECIP_MUL   = ((2 ** RECIP_SHIFT) + 99) / 100;
  localparam int PROD_W      = SCALED_W + RECIP_W;

  localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};
  localparam logic [PCT_W-1:0]     PCT_MAX   = PCT_W'(100);
  localparam logic signed [EFFORT_W-1:0] COAST_BAND = EFFORT_W'(3);

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_LEFT_INV  = 1'b0;
  localparam logic REG_RIGHT_INV = 1'b1;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIR_COAST = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_BACK  = 2'd2,
    DIR_BRAKE = 2'd3
  } dir_t;

  typedef struct packed {
    logic signed [EFFORT_W-1:0] left_effort;
    logic signed [EFFORT_W-1:0] right_effort;
    logic                       armed;
  } cmd_t;

  typedef struct packed {
    logic                 motor_side;
    logic [DUTY_BITS-1:0] duty_a;
    logic [DUTY_BITS-1:0] duty_b;
    logic                 hold_dead_time;
    logic                 last;
  } pwm_t;

  // datapath strobes driven by the microcode
  typedef struct packed {
    logic mul_en;
    logic round_en;
    logic scale_en;
  } calc_ctl_t;

  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    OP_WAIT  = 3'd0,
    OP_MUL   = 3'd1,
    OP_ROUND = 3'd2,
    OP_SCALE = 3'd3,
    OP_DEAD  = 3'd4,
    OP_DRIVE = 3'd5,
    OP_BRAKE = 3'd6,
    OP_NOP   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_NO_CMD   = 2'd1,
    COND_DISARMED = 2'd2,
    COND_ALWAYS   = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    logic             side;
    logic             last;
    cond_t            cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_WAIT  = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_BRAKE = STEP_W'(11);

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NOP, side: SIDE_LEFT, last: 1'b0, cond: COND_ALWAYS, target: STEP_WAIT};
    unique case (step)
      4'd0:  w = '{OP_WAIT,  SIDE_LEFT,  1'b0, COND_NO_CMD,   STEP_WAIT};
      4'd1:  w = '{OP_MUL,   SIDE_LEFT,  1'b0, COND_DISARMED, STEP_BRAKE};
      4'd2:  w = '{OP_ROUND, SIDE_LEFT,  1'b0, COND_NONE,     STEP_WAIT};
      4'd3:  w = '{OP_SCALE, SIDE_LEFT,  1'b0, COND_NONE,     STEP_WAIT};
      4'd4:  w = '{OP_DEAD,  SIDE_LEFT,  1'b0, COND_NONE,     STEP_WAIT};
      4'd5:  w = '{OP_DRIVE, SIDE_LEFT,  1'b0, COND_NONE,     STEP_WAIT};
      4'd6:  w = '{OP_MUL,   SIDE_RIGHT, 1'b0, COND_NONE,     STEP_WAIT};
      4'd7:  w = '{OP_ROUND, SIDE_RIGHT, 1'b0, COND_NONE,     STEP_WAIT};
      4'd8:  w = '{OP_SCALE, SIDE_RIGHT, 1'b0, COND_NONE,     STEP_WAIT};
      4'd9:  w = '{OP_DEAD,  SIDE_RIGHT, 1'b0, COND_NONE,     STEP_WAIT};
      4'd10: w = '{OP_DRIVE, SIDE_RIGHT, 1'b1, COND_ALWAYS,   STEP_WAIT};
      4'd11: w = '{OP_BRAKE, SIDE_LEFT,  1'b0, COND_NONE,     STEP_WAIT};
      4'd12: w = '{OP_BRAKE, SIDE_RIGHT, 1'b1, COND_ALWAYS,   STEP_WAIT};
      default: w = '{OP_NOP, SIDE_LEFT,  1'b0, COND_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/hbep_calc.sv
// Effort magnitude to duty datapath: scale to percent, round, rescale to duty.
`default_nettype none
module hbep_calc (
  input  wire logic                                clk,
  input  wire hbep_pkg::calc_ctl_t                 ctl,
  input  wire logic signed [hbep_pkg::EFFORT_W-1:0] effort,
  output logic             [hbep_pkg::DUTY_BITS-1:0] duty
);
  import hbep_pkg::*;

  logic [EFFORT_W-1:0]   mag;
  logic [MAG_N_W-1:0]    mag_n;
  logic [MAG_N_W-FRAC_W-1:0] q;
  logic [FRAC_W-1:0]     r;
  logic                  round_up;
  logic [MAG_N_W-FRAC_W-1:0] q_rnd;
  logic [PCT_W-1:0]      pct;
  logic [SCALED_W-1:0]   scaled;
  logic [PROD_W-1:0]     prod;

  // two's complement negate in 16 bits also covers -1.0 -> 0x8000
  assign mag = effort[EFFORT_W-1] ? EFFORT_W'(-effort) : EFFORT_W'(effort);

  assign q        = mag_n[MAG_N_W-1:FRAC_W];
  assign r        = mag_n[FRAC_W-1:0];
  assign round_up = (r > {1'b1, {(FRAC_W-1){1'b0}}}) ||
                    ((r == {1'b1, {(FRAC_W-1){1'b0}}}) && q[0]);
  assign q_rnd    = q + (MAG_N_W-FRAC_W)'(round_up);
  assign pct      = (q_rnd > (MAG_N_W-FRAC_W)'(PCT_MAX)) ? PCT_MAX : q_rnd[PCT_W-1:0];
  assign prod     = PROD_W'(scaled) * PROD_W'(RECIP_MUL);

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      mag_n <= MAG_N_W'(mag) * MAG_N_W'(PCT_MAX);
    end
    if (ctl.round_en) begin
      // pct * (2^DUTY_BITS - 1)
      scaled <= (SCALED_W'(pct) << DUTY_BITS) - SCALED_W'(pct);
    end
    if (ctl.scale_en) begin
      duty <= prod[RECIP_SHIFT +: DUTY_BITS];
    end
  end

endmodule
`default_nettype wire

>>> rtl/h_bridge_effort_to_pwm.sv
// Top level: microcoded sequencer turning motor efforts into H-bridge duty requests.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------
//  cmd      | cmd_valid / cmd_ready         | cmd (cmd_t)
//  pwm      | pwm_valid / pwm_ready         | pwm (pwm_t)
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A request is taken only at the wait step of the ROM program. Armed requests
// run two passes of multiply, round, scale, dead-time and drive steps, disarmed
// requests two brake steps. A full output register stalls the emitting step;
// the register frees the datapath from the consumer. Synchronous reset puts the
// program at the wait step, both motors at coast and both inversion bits at 0.
`default_nettype none
module h_bridge_effort_to_pwm (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cmd_valid,
  output logic                                      cmd_ready,
  input  wire hbep_pkg::cmd_t                       cmd,
  output logic                                      pwm_valid,
  input  wire logic                                 pwm_ready,
  output hbep_pkg::pwm_t                            pwm,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [hbep_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);
  import hbep_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  cmd_t              cmd_reg;
  logic              left_inv;
  logic              right_inv;
  dir_t              left_dir;
  dir_t              right_dir;
  dir_t              old_dir;
  dir_t              new_dir;
  logic signed [EFFORT_W-1:0] effort;
  logic              inv;
  logic              reversal;
  logic              out_free;
  logic              emit_op;
  logic              stall;
  logic              jump;
  logic              cmd_take;
  logic [DUTY_BITS-1:0] duty;
  calc_ctl_t         calc_ctl;

  assign uw = ucode_rom(step);

  assign cmd_ready = (uw.op == OP_WAIT);
  assign cmd_take  = cmd_valid && cmd_ready;

  // per-side operand selection
  assign effort  = (uw.side == SIDE_RIGHT) ? cmd_reg.right_effort : cmd_reg.left_effort;
  assign inv     = (uw.side == SIDE_RIGHT) ? right_inv : left_inv;
  assign old_dir = (uw.side == SIDE_RIGHT) ? right_dir : left_dir;

  always_comb begin
    if ((effort >= -COAST_BAND) && (effort <= COAST_BAND)) begin
      new_dir = DIR_COAST;
    end else if ((effort > 0) ^ inv) begin
      new_dir = DIR_FWD;
    end else begin
      new_dir = DIR_BACK;
    end
  end

  assign reversal = ((old_dir == DIR_FWD) && (new_dir == DIR_BACK)) ||
                    ((old_dir == DIR_BACK) && (new_dir == DIR_FWD));

  assign out_free = !pwm_valid || pwm_ready;
  assign emit_op  = (uw.op == OP_DEAD) || (uw.op == OP_DRIVE) || (uw.op == OP_BRAKE);
  assign stall    = emit_op && !out_free;

  always_comb begin
    unique case (uw.cond)
      COND_NONE:     jump = 1'b0;
      COND_NO_CMD:   jump = !cmd_valid;
      COND_DISARMED: jump = !cmd_reg.armed;
      COND_ALWAYS:   jump = 1'b1;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      step_next = step;
    end else if (jump) begin
      step_next = uw.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  assign calc_ctl.mul_en   = (uw.op == OP_MUL);
  assign calc_ctl.round_en = (uw.op == OP_ROUND);
  assign calc_ctl.scale_en = (uw.op == OP_SCALE);

  hbep_calc u_calc (
    .clk    (clk),
    .ctl    (calc_ctl),
    .effort (effort),
    .duty   (duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_WAIT;
      pwm_valid <= 1'b0;
      left_dir  <= DIR_COAST;
      right_dir <= DIR_COAST;
    end else begin
      step <= step_next;
      // out_free: the register is empty or its request leaves at this edge
      if (out_free) begin
        unique case (uw.op)
          OP_DEAD: begin
            pwm_valid <= reversal;
          end
          OP_DRIVE, OP_BRAKE: begin
            pwm_valid <= 1'b1;
            if (uw.side == SIDE_RIGHT) begin
              right_dir <= (uw.op == OP_BRAKE) ? DIR_BRAKE : new_dir;
            end else begin
              left_dir  <= (uw.op == OP_BRAKE) ? DIR_BRAKE : new_dir;
            end
          end
          default: begin
            pwm_valid <= 1'b0;
          end
        endcase
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (uw.op)
        OP_DEAD: begin
          pwm <= '{motor_side: uw.side, duty_a: '0, duty_b: '0,
                   hold_dead_time: 1'b1, last: 1'b0};
        end
        OP_DRIVE: begin
          pwm.motor_side     <= uw.side;
          pwm.duty_a         <= (new_dir == DIR_FWD)  ? duty : '0;
          pwm.duty_b         <= (new_dir == DIR_BACK) ? duty : '0;
          pwm.hold_dead_time <= 1'b0;
          pwm.last           <= uw.last;
        end
        OP_BRAKE: begin
          pwm <= '{motor_side: uw.side, duty_a: DUTY_FULL, duty_b: DUTY_FULL,
                   hold_dead_time: 1'b0, last: uw.last};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_reg <= cmd;
    end
  end

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_inv  <= 1'b0;
      right_inv <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_LEFT_INV:  left_inv  <= pwdata[0];
        REG_RIGHT_INV: right_inv <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEFT_INV:  prdata = {31'b0, left_inv};
      REG_RIGHT_INV: prdata = {31'b0, right_inv};
      default:       prdata = '0;
    endcase
  end

  // every request ends on the right motor
  a_last_right: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && pwm.last |-> pwm.motor_side == SIDE_RIGHT)
    else $error("last result not on right motor");

  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && pwm.hold_dead_time |-> pwm.duty_a == '0 && pwm.duty_b == '0 && !pwm.last)
    else $error("dead-time result carries drive");

  a_both_full: assert property (@(posedge clk) disable iff (rst)
    pwm_valid && pwm.duty_a != '0 && pwm.duty_b != '0 |->
      pwm.duty_a == DUTY_FULL && pwm.duty_b == DUTY_FULL)
    else $error("both bridge inputs driven outside brake");

  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(step))
    else $error("sequencer advanced while output blocked");

endmodule
`default_nettype wire

>>> bench/h_bridge_effort_to_pwm_tb.sv
// Self-checking testbench for the H-bridge effort to PWM duty converter.
`timescale 1ns / 100ps
module h_bridge_effort_to_pwm_tb;
  import hbep_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LEFT_INV  = CFG_ADDR_W'(4 * int'(REG_LEFT_INV));
  localparam logic [CFG_ADDR_W-1:0] ADDR_RIGHT_INV = CFG_ADDR_W'(4 * int'(REG_RIGHT_INV));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic pwm_valid;
  logic pwm_ready = 1'b0;
  pwm_t pwm;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // bench copy of the block's state and registers
  logic left_inv_m = 1'b0;
  logic right_inv_m = 1'b0;
  dir_t left_dir_m = DIR_COAST;
  dir_t right_dir_m = DIR_COAST;

  pwm_t expected_pwm[$];
  pwm_t pwm_want;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cmds_sent = 0;
  int pwm_checked = 0;
  int cycles = 0;

  h_bridge_effort_to_pwm i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .pwm_valid(pwm_valid), .pwm_ready(pwm_ready), .pwm(pwm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $realtime, expected_pwm.size());
      $display("h_bridge_effort_to_pwm_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    pwm_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pwm_valid && pwm_ready) begin
      if (expected_pwm.size() == 0) begin
        errors++;
        $display("%0t: unexpected result side=%0d a=%0d b=%0d hold=%0d last=%0d", $realtime,
                 pwm.motor_side, pwm.duty_a, pwm.duty_b, pwm.hold_dead_time, pwm.last);
      end else begin
        pwm_want = expected_pwm.pop_front();
        pwm_checked++;
        if (pwm.motor_side !== pwm_want.motor_side || pwm.duty_a !== pwm_want.duty_a ||
            pwm.duty_b !== pwm_want.duty_b || pwm.hold_dead_time !== pwm_want.hold_dead_time ||
            pwm.last !== pwm_want.last) begin
          errors++;
          $display("%0t: mismatch exp side=%0d a=%0d b=%0d hold=%0d last=%0d", $realtime,
                   pwm_want.motor_side, pwm_want.duty_a, pwm_want.duty_b,
                   pwm_want.hold_dead_time, pwm_want.last);
          $display("%0t:          got side=%0d a=%0d b=%0d hold=%0d last=%0d", $realtime,
                   pwm.motor_side, pwm.duty_a, pwm.duty_b, pwm.hold_dead_time, pwm.last);
        end
      end
    end
  end

  // percent of full scale, ties to even, then scaled to the duty range
  function automatic logic [DUTY_BITS-1:0] duty_of_mag(input int mag);
    int n, q, r;
    if (mag > 32768) mag = 32768;
    n = mag * 100;
    q = n >> 15;
    r = n & 32'h7FFF;
    if (r > 16384 || (r == 16384 && (q & 1) == 1)) q++;
    if (q > 100) q = 100;
    return DUTY_BITS'(q * int'(DUTY_FULL) / 100);
  endfunction

  task automatic predict_motor(input logic side, input logic signed [EFFORT_W-1:0] effort,
                               input logic inv, input logic is_last, inout dir_t dir);
    int ev, mag;
    dir_t next_dir;
    logic [DUTY_BITS-1:0] duty;
    logic fwd;
    ev = effort;
    mag = (ev < 0) ? -ev : ev;
    if (mag <= int'(COAST_BAND)) begin
      next_dir = DIR_COAST;
    end else begin
      fwd = (ev > 0) ^ inv;
      next_dir = fwd ? DIR_FWD : DIR_BACK;
    end
    duty = duty_of_mag(mag);
    if ((dir == DIR_FWD && next_dir == DIR_BACK) || (dir == DIR_BACK && next_dir == DIR_FWD))
      expected_pwm.push_back('{side, '0, '0, 1'b1, 1'b0});
    case (next_dir)
      DIR_FWD:  expected_pwm.push_back('{side, duty, '0, 1'b0, is_last});
      DIR_BACK: expected_pwm.push_back('{side, '0, duty, 1'b0, is_last});
      default:  expected_pwm.push_back('{side, '0, '0, 1'b0, is_last});
    endcase
    dir = next_dir;
  endtask

  task automatic predict_cmd(input cmd_t c);
    if (!c.armed) begin
      expected_pwm.push_back('{SIDE_LEFT, DUTY_FULL, DUTY_FULL, 1'b0, 1'b0});
      expected_pwm.push_back('{SIDE_RIGHT, DUTY_FULL, DUTY_FULL, 1'b0, 1'b1});
      left_dir_m = DIR_BRAKE;
      right_dir_m = DIR_BRAKE;
    end else begin
      predict_motor(SIDE_LEFT, c.left_effort, left_inv_m, 1'b0, left_dir_m);
      predict_motor(SIDE_RIGHT, c.right_effort, right_inv_m, 1'b1, right_dir_m);
    end
  endtask

  // valid stays high across back-to-back requests; it drops only for idle gaps
  task automatic send_cmd(input logic signed [EFFORT_W-1:0] left_e,
                          input logic signed [EFFORT_W-1:0] right_e, input logic armed);
    cmd_t c;
    c.left_effort = left_e;
    c.right_effort = right_e;
    c.armed = armed;
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (!cmd_ready);
    predict_cmd(c);
    cmds_sent++;
  endtask

  task automatic wait_drain();
    cmd_valid <= 1'b0;
    while (expected_pwm.size() != 0) @(posedge clk);
  endtask

  task automatic settle_idle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (idx == REG_LEFT_INV) ? ADDR_LEFT_INV : ADDR_RIGHT_INV;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LEFT_INV) left_inv_m = data[0];
    else right_inv_m = data[0];
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] want;
    want = {31'b0, (idx == REG_LEFT_INV) ? left_inv_m : right_inv_m};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= (idx == REG_LEFT_INV) ? ADDR_LEFT_INV : ADDR_RIGHT_INV;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read exp %h got %h", $realtime, idx, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [EFFORT_W-1:0] pick_effort();
    int sel, mag;
    sel = $urandom_range(9);
    case (sel)
      0, 1: return EFFORT_W'(int'($urandom_range(10)) - 5);
      2: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      3: begin
        // exact half-percent points
        mag = 4096 + 8192 * int'($urandom_range(3));
        return EFFORT_W'($urandom_range(1) ? -mag : mag);
      end
      default: return EFFORT_W'($urandom);
    endcase
  endfunction

  task automatic test_reset_values();
    check_reg(REG_LEFT_INV);
    check_reg(REG_RIGHT_INV);
  endtask

  task automatic test_directed_drive();
    send_idle_pct = 20;
    recv_stall_pct = 20;
    send_cmd(16'sd0, 16'sd0, 1'b1);
    send_cmd(16'sd3, -16'sd3, 1'b1);
    send_cmd(16'sd4, -16'sd4, 1'b1);
    send_cmd(16'sh7FFF, 16'sh8000, 1'b1);
    send_cmd(16'sh8000, 16'sh7FFF, 1'b1);   // reversal on both motors
    send_cmd(16'sh1234, -16'sh1234, 1'b0);  // brake
    send_cmd(-16'sd4096, 16'sd12288, 1'b1); // out of brake, no dead time
    send_cmd(16'sd20480, -16'sd28672, 1'b1);
    send_cmd(16'sd0, -16'sd28672, 1'b1);
    send_cmd(-16'sd1, 16'sd1, 1'b1);
  endtask

  task automatic test_inversion();
    settle_idle();
    write_reg(REG_LEFT_INV, 32'h0000_0001);
    check_reg(REG_LEFT_INV);
    send_cmd(16'sd1000, 16'sd1000, 1'b1);
    send_cmd(-16'sd1000, -16'sd1000, 1'b1);
    settle_idle();
    write_reg(REG_LEFT_INV, 32'hFFFF_FFFE);
    write_reg(REG_RIGHT_INV, 32'hFFFF_FFFF);
    check_reg(REG_LEFT_INV);
    check_reg(REG_RIGHT_INV);
    send_cmd(16'sd1000, 16'sd1000, 1'b1);
    send_cmd(-16'sd1000, -16'sd1000, 1'b1);
    settle_idle();
    write_reg(REG_LEFT_INV, 32'h0000_0001);
    send_cmd(16'sh8000, 16'sh7FFF, 1'b1);
    send_cmd(16'sh7FFF, 16'sh8000, 1'b1);
  endtask

  task automatic test_random_phase(input int n_cmds, input int idle_pct, input int stall_pct,
                                   input bit pause_midway);
    logic signed [EFFORT_W-1:0] l_e, r_e;
    settle_idle();
    write_reg(REG_LEFT_INV, $urandom);
    write_reg(REG_RIGHT_INV, $urandom);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_cmds; i++) begin
      if (pause_midway && i == n_cmds / 2) wait_drain();
      l_e = pick_effort();
      r_e = pick_effort();
      // mostly armed; sometimes the newly picked left effort has its sign flipped
      if ($urandom_range(3) == 0) l_e = -l_e;
      send_cmd(l_e, r_e, $urandom_range(9) != 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_drive();
    test_inversion();
    test_random_phase(88, 0, 0, 1'b0);
    test_random_phase(88, 73, 0, 1'b1);
    test_random_phase(88, 0, 73, 1'b0);
    test_random_phase(88, 29, 29, 1'b0);
    settle_idle();
    $display("covered: %0d requests, %0d duty results checked", cmds_sent, pwm_checked);
    $display("coast band, brake, reversal dead time, rounding ties, inversion settings");
    if (errors == 0) begin
      $display("h_bridge_effort_to_pwm_tb: done, clean");
    end else begin
      $display("h_bridge_effort_to_pwm_tb: done, errors");
    end
    $finish;
  end

endmodule
